FILE: design/bmhpq_pkg.sv
// shared types and constants for the binary min-heap priority queue
`timescale 1ns / 1ps

package bmhpq_pkg;

	localparam int HEAP_DEPTH = 256;
	localparam int KEY_W      = 32;
	localparam int HANDLE_W   = 10;
	localparam int CAP_W      = 9;
	localparam int COUNT_W    = 9;
	localparam int CAP_RESET  = 256;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		op_t    op;
		entry_t entry;
	} req_t;

	// one request slot with its valid flag, passed between front, queue and back
	typedef struct packed {
		logic valid;
		req_t req;
	} req_slot_t;

endpackage

FILE: design/bmhpq_front.sv
// front stage: accepts stream requests and turns them into heap operations
`timescale 1ns / 1ps

module bmhpq_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [bmhpq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic                              s_axis_tuser,
	output bmhpq_pkg::req_slot_t              push,
	input  logic                              push_ready
);
	import bmhpq_pkg::*;

	logic valid_s1;
	req_t req_s1;
	req_t req_in;
	logic take;

	always_comb begin
		req_in.op = op_t'(s_axis_tuser);
		if (req_in.op == OP_INSERT) begin
			req_in.entry.key    = s_axis_tdata[KEY_W-1:0];
			req_in.entry.handle = s_axis_tdata[KEY_W +: HANDLE_W];
		end else begin
			// payload means nothing on an extract
			req_in.entry = '0;
		end
	end

	assign s_axis_tready = !valid_s1 || push_ready;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req_in;
		end
	end

	assign push.valid = valid_s1;
	assign push.req   = req_s1;

endmodule

FILE: design/bmhpq_fifo.sv
// two-entry request queue between the front and the heap engine
`timescale 1ns / 1ps

module bmhpq_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmhpq_pkg::req_slot_t push,
	output logic                 push_ready,
	output bmhpq_pkg::req_slot_t head,
	input  logic                 pop
);
	import bmhpq_pkg::*;

	localparam int QD = 2;

	req_t        slot_q [QD];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = (fill_q != 2'(QD));
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (fill_q != 2'd0);

	assign head.valid = (fill_q != 2'd0);
	assign head.req   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.req;
		end
	end

endmodule

FILE: design/bmhpq_back.sv
// heap engine: entry memory, sift-up and sift-down sequencer, result register
`timescale 1ns / 1ps

module bmhpq_back #(
	parameter int DEPTH = bmhpq_pkg::HEAP_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bmhpq_pkg::req_slot_t               head,
	output logic                               pop,
	input  logic [bmhpq_pkg::CAP_W-1:0]        capacity,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [bmhpq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic [1:0]                         m_axis_tuser
);
	import bmhpq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CH_W  = IDX_W + 2;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_INS_RD  = 8'b0000_0010,
		S_INS_CMP = 8'b0000_0100,
		S_EXT_RD  = 8'b0000_1000,
		S_EXT_LD  = 8'b0001_0000,
		S_DN_RD   = 8'b0010_0000,
		S_DN_CMP  = 8'b0100_0000,
		S_WR      = 8'b1000_0000
	} state_t;

	state_t           state_q;
	logic             finish_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] pos_q;
	entry_t           held_q;
	status_t          res_status_q;
	entry_t           res_entry_q;

	entry_t           heap_mem_q [DEPTH];
	entry_t           rd_a_q;
	entry_t           rd_b_q;
	logic [IDX_W-1:0] rd_addr_a;
	logic [IDX_W-1:0] rd_addr_b;
	logic             mem_we;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic             out_valid_q;
	status_t          out_status_q;
	entry_t           out_entry_q;
	logic [CNT_W-1:0] out_count_q;

	logic [IDX_W-1:0] parent_idx;
	logic [CH_W-1:0]  left_idx;
	logic [CH_W-1:0]  right_idx;
	logic             left_ok;
	logic             right_ok;
	logic             take_left;
	logic             take_right;
	logic [KEY_W-1:0] best_key;
	logic             is_full;
	logic             out_free;
	logic             load_out;
	logic             held_less;

	assign parent_idx = IDX_W'((pos_q - 1'b1) >> 1);
	assign left_idx   = CH_W'({pos_q, 1'b1});
	assign right_idx  = left_idx + CH_W'(1);
	assign left_ok    = left_idx < CH_W'(count_q);
	assign right_ok   = right_idx < CH_W'(count_q);
	assign take_left  = left_ok && (rd_a_q.key < held_q.key);
	assign best_key   = take_left ? rd_a_q.key : held_q.key;
	assign take_right = right_ok && (rd_b_q.key < best_key);
	assign held_less  = held_q.key < rd_a_q.key;

	// full against the programmed capacity and against the memory size
	assign is_full = (CMP_W'(count_q) >= CMP_W'(capacity)) || (count_q == CNT_W'(DEPTH));

	assign out_free = !out_valid_q || m_axis_tready;
	assign load_out = finish_q && out_free;
	assign pop      = (state_q == S_IDLE) && !finish_q && head.valid;

	always_comb begin
		rd_addr_a = '0;
		rd_addr_b = '0;
		mem_we    = 1'b0;
		wr_addr   = pos_q;
		wr_data   = held_q;
		unique case (state_q)
			S_IDLE: ;
			S_INS_RD: rd_addr_a = parent_idx;
			S_INS_CMP: begin
				mem_we  = 1'b1;
				wr_data = held_less ? rd_a_q : held_q;
			end
			S_EXT_RD: rd_addr_b = IDX_W'(count_q);
			S_EXT_LD: ;
			S_DN_RD: begin
				rd_addr_a = IDX_W'(left_idx);
				rd_addr_b = IDX_W'(right_idx);
			end
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (take_right) begin
					wr_data = rd_b_q;
				end else if (take_left) begin
					wr_data = rd_a_q;
				end
			end
			S_WR: mem_we = 1'b1;
			default: ;
		endcase
	end

	// on extract the root comes out on port a and the last entry on port b together
	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= heap_mem_q[rd_addr_a];
		rd_b_q <= heap_mem_q[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			finish_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (load_out) begin
				finish_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (head.req.op == OP_INSERT) begin
							if (is_full) begin
								finish_q <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
								state_q <= (count_q == '0) ? S_WR : S_INS_RD;
							end
						end else begin
							if (count_q == '0) begin
								finish_q <= 1'b1;
							end else begin
								count_q <= count_q - CNT_W'(1);
								state_q <= S_EXT_RD;
							end
						end
					end
				end
				S_INS_RD: state_q <= S_INS_CMP;
				S_INS_CMP: begin
					if (held_less && parent_idx != '0) begin
						state_q <= S_INS_RD;
					end else if (held_less) begin
						state_q <= S_WR;
					end else begin
						state_q  <= S_IDLE;
						finish_q <= 1'b1;
					end
				end
				S_EXT_RD: state_q <= S_EXT_LD;
				S_EXT_LD: begin
					if (count_q == '0) begin
						state_q  <= S_IDLE;
						finish_q <= 1'b1;
					end else begin
						state_q <= S_DN_RD;
					end
				end
				S_DN_RD: state_q <= S_DN_CMP;
				S_DN_CMP: begin
					if (take_left || take_right) begin
						state_q <= S_DN_RD;
					end else begin
						state_q  <= S_IDLE;
						finish_q <= 1'b1;
					end
				end
				S_WR: begin
					state_q  <= S_IDLE;
					finish_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					held_q      <= head.req.entry;
					pos_q       <= IDX_W'(count_q);
					res_entry_q <= '0;
					if (head.req.op == OP_INSERT) begin
						res_status_q <= is_full ? STAT_FULL : STAT_OK;
					end else begin
						res_status_q <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
					end
				end
			end
			S_INS_CMP: begin
				if (held_less) begin
					pos_q <= parent_idx;
				end
			end
			S_EXT_LD: begin
				res_entry_q <= rd_a_q;
				held_q      <= rd_b_q;
				pos_q       <= '0;
			end
			S_DN_CMP: begin
				if (take_right) begin
					pos_q <= IDX_W'(right_idx);
				end else if (take_left) begin
					pos_q <= IDX_W'(left_idx);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_entry_q  <= res_entry_q;
			out_count_q  <= count_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = OUT_DATA_W'({COUNT_W'(out_count_q), out_entry_q.handle,
		out_entry_q.key});

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above heap depth");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CNT_W'(wr_addr) < count_q))
		else $error("heap write outside live entries");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && res_status_q == STAT_EMPTY) |-> (count_q == '0))
		else $error("empty report with entries held");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE && !finish_q))
		else $error("request taken while engine busy");
`endif

endmodule

FILE: design/binary_min_heap_priority_queue_unit.sv
// Binary min-heap priority queue: insert and extract-minimum over stream channels.
//
// Requests arrive on s_axis: tuser is the action (0 insert, 1 extract minimum),
// tdata carries the key and handle of an insert. Each request gives exactly one
// result on m_axis: tuser is the status (ok, insert dropped on full heap,
// extract from empty heap), tdata carries the extracted key and handle (zero
// otherwise) and the entry count after the request.
// cfg_data sets the capacity in use; it is taken whenever cfg_valid is high and
// should only change while no request is outstanding.
// From s_axis accept to m_axis_tvalid, an insert climbs level by level until its
// parent is not larger or it reaches the root, or is dropped on a full heap; an
// extract reads the root and the last entry, then descends level by level unless
// it empties the heap, or reports an empty heap. The engine serves one request at
// a time, limited by the single entry memory: each level needs one registered
// read and one compare-and-write. A request register and a two-entry queue let
// new requests be taken while it works. Reset clears the entry count and queue
// and sets the capacity to 256; the entry memory is not cleared. When the
// receiver stalls the result is held in the output register, the engine stops at
// its next result and the queue fills, after which s_axis_tready drops.
`timescale 1ns / 1ps

module binary_min_heap_priority_queue_unit #(
	parameter int DEPTH = bmhpq_pkg::HEAP_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [bmhpq_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // key[31:0], handle[41:32]
	input  logic                              s_axis_tuser,  // action
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [bmhpq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // out_key, out_handle, count
	output logic [1:0]                        m_axis_tuser,  // status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bmhpq_pkg::CAP_W-1:0]       cfg_data
);
	import bmhpq_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	req_slot_t        front_push;
	logic             front_ready;
	req_slot_t        queue_head;
	logic             queue_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(CAP_RESET);
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	bmhpq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (front_push),
		.push_ready    (front_ready)
	);

	bmhpq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_push),
		.push_ready (front_ready),
		.head       (queue_head),
		.pop        (queue_pop)
	);

	bmhpq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (queue_head),
		.pop           (queue_pop),
		.capacity      (capacity_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
